// File: rtl/core/cfo_pkg.sv
// Shared constants, types and functions for the complementary filter core.
package cfo_pkg;

	localparam int AccW   = 16;
	localparam int AngW   = 20;
	localparam int TsW    = 48;
	localparam int CzW    = 28;
	localparam int CvW    = 40;

	localparam logic signed [AngW-1:0] PiQ16    = 20'sd205887;
	localparam logic signed [AngW-1:0] TwoPiQ16 = 20'sd411774;
	localparam logic signed [CzW-1:0]  PiQ24    = 28'sd52707179;
	localparam logic [TsW-1:0]         OneSecUs = 48'd1000000;
	localparam logic signed [23:0]     DegScale = 24'sd3754936;
	localparam logic [16:0]            AlphaOne = 17'd65536;

	typedef logic signed [AngW-1:0] angle_t;

	// per-step rotation angle in Q.24
	function automatic logic signed [CzW-1:0] step_angle(input logic [4:0] i);
		logic signed [CzW-1:0] r;
		begin
			unique case (i)
				5'd0: r = 28'sd13176795;
				5'd1: r = 28'sd7778716;
				5'd2: r = 28'sd4110060;
				5'd3: r = 28'sd2086331;
				5'd4: r = 28'sd1047214;
				5'd5: r = 28'sd524117;
				5'd6: r = 28'sd262123;
				5'd7: r = 28'sd131069;
				default: r = (i <= 5'd24) ? (28'sd1 <<< (5'd24 - i)) : 28'sd0;
			endcase
			return r;
		end
	endfunction

	// wrap a value known to lie within a few turns of zero, one turn per call
	function automatic logic signed [AngW+3:0] wrap_once(input logic signed [AngW+3:0] a);
		begin
			if (a > 24'(PiQ16)) return a - 24'(TwoPiQ16);
			else if (a < -24'(PiQ16)) return a + 24'(TwoPiQ16);
			else return a;
		end
	endfunction

endpackage

// File: rtl/core/cfo_cordic.sv
// Iterative CORDIC vectoring unit: atan2(y, x) in radians Q3.16.
module cfo_cordic #(
	parameter int STEPS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [cfo_pkg::CvW-1:0] y_in,
	input  logic signed [cfo_pkg::CvW-1:0] x_in,
	output logic                          done,
	output logic signed [cfo_pkg::AngW-1:0] angle
);
	import cfo_pkg::*;

	logic signed [CvW+1:0] x_q, y_q;
	logic signed [CzW+1:0] z_q;
	logic [4:0] i_q;
	logic busy_q;
	logic signed [CzW+1:0] sum;

	assign sum = z_q + 30'sd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			i_q    <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				if (x_in < 0) begin
					x_q <= -(42'(x_in));
					y_q <= -(42'(y_in));
					z_q <= (y_in >= 0) ? 30'(PiQ24) : -30'(PiQ24);
				end else begin
					x_q <= 42'(x_in);
					y_q <= 42'(y_in);
					z_q <= '0;
				end
				i_q    <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				// y on an axis is only checked before the first rotation
				if ((i_q == 5'd0 && y_q == 0) || i_q == 5'(STEPS)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					angle  <= AngW'(sum >>> 8);
				end else begin
					if (y_q > 0) begin
						x_q <= x_q + (y_q >>> i_q);
						y_q <= y_q - (x_q >>> i_q);
						z_q <= z_q + 30'(step_angle(i_q));
					end else begin
						x_q <= x_q - (y_q >>> i_q);
						y_q <= y_q + (x_q >>> i_q);
						z_q <= z_q - 30'(step_angle(i_q));
					end
					i_q <= i_q + 5'd1;
				end
			end
		end
	end
endmodule

// File: rtl/core/cfo_isqrt.sv
// Bitwise integer square root, two radicand bits per cycle.
module cfo_isqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [47:0] radicand,
	output logic        done,
	output logic [23:0] root
);
	logic [47:0] v_q, res_q, bit_q;
	logic busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				v_q    <= radicand;
				res_q  <= '0;
				bit_q  <= 48'h4000_0000_0000;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (bit_q == 0) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
					root   <= res_q[23:0];
				end else begin
					if (v_q >= res_q + bit_q) begin
						v_q   <= v_q - (res_q + bit_q);
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end
			end
		end
	end
endmodule

// File: rtl/core/complementary_filter_orientation_core.sv
// Top level of the complementary filter attitude core.
// Steps from accept to m_tvalid: roll CORDIC pass, square root, pitch CORDIC pass, gyro,
//   blend, wrap, degree and output; the first item skips gyro and blend, and a CORDIC
//   pass starting at y zero ends before its first rotation.
// A new item is taken only when idle: s_tready is low while an item is in work,
//   and a result still waiting in the output register holds only the output step.
// Reset (arst_n low, asynchronous): unseeded, time and angles zero, alpha 64225.
module complementary_filter_orientation_core #(
	parameter int CORDIC_STEPS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [16:0]  cfg_data,     // gyro_weight
	input  logic         s_tvalid,
	output logic         s_tready,
	// [47:0] timestamp_us, [63:48] accel_x, [79:64] accel_y, [95:80] accel_z,
	// [111:96] gyro_x, [127:112] gyro_y, [143:128] gyro_z
	input  logic [143:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [18:0] roll_rad, [37:19] pitch_rad, [56:38] yaw_rad,
	// [73:57] roll_deg, [90:74] pitch_deg, [107:91] yaw_deg, [111:108] zero
	output logic [111:0] m_tdata
);
	import cfo_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE, ST_ROLL, ST_SQRT, ST_PITCH, ST_GYRO, ST_BLEND_R, ST_BLEND_P,
		ST_WRAP, ST_DEG, ST_OUT
	} state_t;

	state_t state_q;
	logic [16:0] alpha_q;
	logic seeded_q;
	logic [TsW-1:0] prev_q, ts_q;
	angle_t roll_q, pitch_q, yaw_q, roll_acc_q, pitch_acc_q;
	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q, gz_q;
	logic [20:0] dt_q;
	logic [1:0] idx_q;
	logic [1:0] ph_q;
	logic signed [AngW+3:0] w_q [3];
	logic signed [16:0] deg_q [3];
	logic signed [39:0] gnum_q, gquo_q, acc_q;

	logic cord_start, cord_done, sq_start, sq_done;
	logic signed [CvW-1:0] cord_y, cord_x;
	angle_t cord_angle;
	logic [23:0] sq_root;
	logic [47:0] radicand;

	// shared multiplier: one product per cycle
	logic signed [24:0] mul_a, mul_b;
	logic signed [49:0] mul_p;
	assign mul_p = mul_a * mul_b;

	assign cfg_ready = (state_q == ST_IDLE);
	assign s_tready  = (state_q == ST_IDLE);

	assign radicand = (48'(32'(ay_q * ay_q)) + 48'(32'(az_q * az_q))) << 16;

	cfo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cord_start),
		.y_in(cord_y), .x_in(cord_x), .done(cord_done), .angle(cord_angle)
	);
	cfo_isqrt u_isqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(radicand),
		.done(sq_done), .root(sq_root)
	);

	logic busy_go;
	assign busy_go = s_tvalid && s_tready;
	assign cord_start = busy_go || (state_q == ST_SQRT && sq_done);
	assign sq_start   = (state_q == ST_ROLL && cord_done);
	always_comb begin
		if (state_q == ST_SQRT) begin
			cord_y = -(40'(ax_q) <<< 8);
			cord_x = 40'(sq_root);
		end else begin
			cord_y = 40'(signed'(s_tdata[79:64])) <<< 8;
			cord_x = 40'(signed'(s_tdata[95:80])) <<< 8;
		end
	end

	logic [16:0] alpha_eff;
	assign alpha_eff = (alpha_q > AlphaOne) ? AlphaOne : alpha_q;

	// operand select for the shared multiplier
	logic signed [AngW+3:0] gsel;
	angle_t bsel, gbase;
	always_comb begin
		gsel = idx_q == 2'd0 ? 24'(gx_q) : (idx_q == 2'd1 ? 24'(gy_q) : 24'(gz_q));
		gbase = idx_q == 2'd0 ? roll_q : (idx_q == 2'd1 ? pitch_q : yaw_q);
		bsel = idx_q == 2'd0 ? roll_acc_q : pitch_acc_q;
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_GYRO: begin
				mul_a = 25'(gsel);
				mul_b = 25'(signed'({1'b0, dt_q}));
			end
			ST_BLEND_R, ST_BLEND_P: begin
				// alpha times gyro angle first, then the accelerometer share
				if (ph_q == 2'd0) begin
					mul_a = 25'(signed'({1'b0, alpha_eff}));
					mul_b = 25'(w_q[idx_q]);
				end else begin
					mul_a = 25'(signed'({1'b0, AlphaOne - alpha_eff}));
					mul_b = 25'(bsel);
				end
			end
			ST_DEG: begin
				mul_a = 25'(w_q[idx_q]);
				mul_b = 25'(DegScale);
			end
			default: ;
		endcase
	end

	// gyro increment: floor((p + 31250) / 62500) via reciprocal, then one-step correction
	logic signed [65:0] recip;
	logic signed [39:0] grem, gq;
	assign recip = gnum_q * 26'sd17592186; // 2^40/62500, rounded down
	assign grem  = gnum_q - gquo_q * 40'sd62500;
	always_comb begin
		gq = gquo_q;
		if (grem >= 40'sd62500) gq = gquo_q + 40'sd1;
		else if (grem < 40'sd0) gq = gquo_q - 40'sd1;
	end

	logic signed [39:0] blend_s;
	assign blend_s = acc_q + 40'(mul_p) + 40'sd32768;

	logic signed [49:0] deg_s;
	assign deg_s = (mul_p + 50'sd8388608) >>> 24;

	logic [TsW-1:0] tdiff;
	assign tdiff = ts_q - prev_q;

	// output register loads once the previous result has left
	logic out_load;
	assign out_load = (state_q == ST_OUT) && (!m_tvalid || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			alpha_q  <= 17'd64225;
			seeded_q <= 1'b0;
			prev_q   <= '0;
			roll_q   <= '0;
			pitch_q  <= '0;
			yaw_q    <= '0;
			m_tvalid <= 1'b0;
			idx_q    <= '0;
			ph_q     <= '0;
		end else begin
			if (out_load) m_tvalid <= 1'b1;
			else if (m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_valid) alpha_q <= cfg_data;
					if (busy_go) begin
						ts_q  <= s_tdata[47:0];
						ax_q  <= s_tdata[63:48];
						ay_q  <= s_tdata[79:64];
						az_q  <= s_tdata[95:80];
						gx_q  <= s_tdata[111:96];
						gy_q  <= s_tdata[127:112];
						gz_q  <= s_tdata[143:128];
						state_q <= ST_ROLL;
					end
				end
				ST_ROLL: if (cord_done) begin
					roll_acc_q <= cord_angle;
					state_q <= ST_SQRT;
				end
				ST_SQRT: if (sq_done) state_q <= ST_PITCH;
				ST_PITCH: if (cord_done) begin
					pitch_acc_q <= cord_angle;
					idx_q <= '0;
					ph_q  <= '0;
					if (ts_q > prev_q && tdiff <= OneSecUs) dt_q <= tdiff[20:0];
					else dt_q <= '0;
					if (!seeded_q) begin
						roll_q  <= roll_acc_q;
						pitch_q <= cord_angle;
						w_q[0] <= 24'(roll_acc_q);
						w_q[1] <= 24'(cord_angle);
						w_q[2] <= '0;
						seeded_q <= 1'b1;
						state_q <= ST_WRAP;
					end else begin
						state_q <= ST_GYRO;
					end
					prev_q <= ts_q;
				end
				ST_GYRO: begin
					// per axis: product, reciprocal, correction and add
					unique case (ph_q)
						2'd0: begin
							gnum_q <= 40'(mul_p) + 40'sd31250;
							ph_q <= 2'd1;
						end
						2'd1: begin
							gquo_q <= 40'(recip >>> 40);
							ph_q <= 2'd2;
						end
						default: begin
							w_q[idx_q] <= 24'(40'(gbase) + gq);
							ph_q <= '0;
							if (idx_q == 2'd2) begin
								idx_q <= '0;
								state_q <= ST_BLEND_R;
							end else idx_q <= idx_q + 2'd1;
						end
					endcase
				end
				ST_BLEND_R: begin
					if (ph_q == 2'd0) begin
						acc_q <= 40'(mul_p);
						ph_q <= 2'd1;
					end else begin
						w_q[0] <= 24'(blend_s >>> 16);
						ph_q <= '0;
						idx_q <= 2'd1;
						state_q <= ST_BLEND_P;
					end
				end
				ST_BLEND_P: begin
					if (ph_q == 2'd0) begin
						acc_q <= 40'(mul_p);
						ph_q <= 2'd1;
					end else begin
						w_q[1] <= 24'(blend_s >>> 16);
						ph_q <= '0;
						idx_q <= '0;
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					// values stay within two turns; loop until all in range
					for (int k = 0; k < 3; k++) w_q[k] <= wrap_once(w_q[k]);
					if (wrap_once(w_q[0]) == w_q[0] && wrap_once(w_q[1]) == w_q[1]
							&& wrap_once(w_q[2]) == w_q[2]) begin
						roll_q  <= AngW'(w_q[0]);
						pitch_q <= AngW'(w_q[1]);
						yaw_q   <= AngW'(w_q[2]);
						idx_q   <= '0;
						state_q <= ST_DEG;
					end
				end
				ST_DEG: begin
					deg_q[idx_q] <= 17'(deg_s);
					if (idx_q == 2'd2) state_q <= ST_OUT;
					else idx_q <= idx_q + 2'd1;
				end
				ST_OUT: if (out_load) begin
					m_tdata <= {4'd0, deg_q[2], deg_q[1], deg_q[0],
						19'(w_q[2]), 19'(w_q[1]), 19'(w_q[0])};
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// a waiting result is held until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("pending result changed");
	// the stored roll angle always lies within plus or minus pi when idle
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (roll_q <= PiQ16 && roll_q >= -PiQ16))
		else $error("roll out of range");
	// the result register is loaded only from the output step
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q) == ST_OUT)
		else $error("result without output step");
endmodule
